// ===== hdl/mcd_pkg.sv =====
package mcd_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  error_code;
        logic [31:0] chunk_magic;
        logic [31:0] payload_length;
        logic [15:0] pad_length;
        logic [7:0]  channel_number;
        logic [7:0]  payload_type;
        logic [31:0] frm_time;
        logic [31:0] frm_rate;
        logic [7:0]  out_byte;
        logic        last_of_chunk;
    } t_out;

    typedef enum logic [2:0] {
        PH_CHUNK,
        PH_PHDR,
        PH_DATA,
        PH_PAD,
        PH_SKIP
    } t_phase;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_SHORT   = 2'd0;
    localparam logic [1:0] ERR_PAD     = 2'd1;
    localparam logic [1:0] ERR_END     = 2'd2;

    localparam logic [7:0] CFG_FILTER_ON   = 8'd0;
    localparam logic [7:0] CFG_WANTED_TYPE = 8'd1;

    localparam logic [2:0]  HDR_LAST    = 3'd7;
    localparam logic [31:0] MIN_PAYLOAD = 32'd25;
    localparam logic [31:0] PAYLOAD_HDR = 32'd24;

    localparam logic [4:0] POS_PAD_HI   = 5'd2;
    localparam logic [4:0] POS_PAD_LO   = 5'd3;
    localparam logic [4:0] POS_CHANNEL  = 5'd4;
    localparam logic [4:0] POS_TYPE     = 5'd7;
    localparam logic [4:0] POS_TIME     = 5'd8;
    localparam logic [4:0] POS_RATE     = 5'd12;
    localparam logic [4:0] POS_RATE_END = 5'd16;
    localparam logic [4:0] POS_HDR_LAST = 5'd23;

endpackage

// ===== hdl/media_chunk_deframer_core.sv =====
// media_chunk_deframer_core
// takes a chunked container stream one byte per transaction on the input
// channel (i_in_valid / o_in_stall / i_in_data) and gives header records,
// data bytes and error records on the output channel (o_out_valid /
// i_out_stall / o_out_data)
// a byte yields zero or one result; the result shows on the output in the cycle
// after its byte is accepted, held in a single output register
// throughput is one byte per cycle when not stalled, set by the single state
// update from the input byte into the chunk registers and the output register
// o_in_stall rises only while the output register holds a result and the
// receiver stalls; a taken result frees the register in the same cycle, so
// the next byte is accepted at once
// the configuration channel (i_cfg_valid / o_cfg_ready) is always ready;
// index 0 enables the type filter, index 1 sets the wanted payload type
// reset (i_rst_n low, synchronous) empties the output register, clears the
// filter settings and returns the parser to the start of a chunk header
module media_chunk_deframer_core
    import mcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_magic, n_magic;
    logic [31:0] r_size, n_size;
    logic [15:0] r_pad, n_pad;
    logic [7:0]  r_channel, n_channel;
    logic [7:0]  r_type, n_type;
    logic [31:0] r_time, n_time;
    logic [31:0] r_rate, n_rate;
    logic [31:0] r_dend, n_dend;
    logic        r_filter_on;
    logic [7:0]  r_wanted_type;
    logic        r_out_valid;
    t_out        r_out;

    logic        accept;
    logic        emit;
    logic [1:0]  e_kind;
    logic [1:0]  e_code;
    logic [7:0]  e_byte;
    logic        e_last;
    logic [31:0] pos_inc;
    logic        complete;
    logic [4:0]  p;
    logic [15:0] pad_new;
    logic        data_last;
    logic [7:0]  b;
    logic        s_end;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign b        = i_in_data.data_byte;
    assign s_end    = i_in_data.stream_end;
    assign pos_inc  = r_pos + 32'd1;
    assign complete = (pos_inc == r_size);
    assign p        = r_pos[4:0];
    assign pad_new  = {r_pad[7:0], b};
    assign data_last = (pos_inc == r_dend);

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_magic   = r_magic;
        n_size    = r_size;
        n_pad     = r_pad;
        n_channel = r_channel;
        n_type    = r_type;
        n_time    = r_time;
        n_rate    = r_rate;
        n_dend    = r_dend;
        emit      = 1'b0;
        e_kind    = KIND_HEADER;
        e_code    = ERR_SHORT;
        e_byte    = 8'd0;
        e_last    = 1'b0;
        unique case (r_phase)
            PH_CHUNK: begin
                if (r_pos[2:0] == 3'd0) begin
                    n_magic   = {24'd0, b};
                    n_size    = 32'd0;
                    n_pad     = 16'd0;
                    n_channel = 8'd0;
                    n_type    = 8'd0;
                    n_time    = 32'd0;
                    n_rate    = 32'd0;
                end else if (!r_pos[2]) begin
                    n_magic = {r_magic[23:0], b};
                end else begin
                    n_size = {r_size[23:0], b};
                end
                if (r_pos[2:0] != HDR_LAST) begin
                    n_pos = s_end ? 32'd0 : {29'd0, pos_inc[2:0]};
                end else begin
                    n_pos = 32'd0;
                    priority if (n_size == 32'd0) begin
                        emit   = 1'b1;
                        e_kind = KIND_ERROR;
                        e_code = ERR_SHORT;
                    end else if (s_end) begin
                        emit   = 1'b1;
                        e_kind = KIND_ERROR;
                        e_code = ERR_END;
                    end else if (n_size < MIN_PAYLOAD) begin
                        n_phase = PH_SKIP;
                        emit    = 1'b1;
                        e_kind  = KIND_ERROR;
                        e_code  = ERR_SHORT;
                    end else begin
                        n_phase = PH_PHDR;
                    end
                end
            end
            PH_PHDR, PH_DATA, PH_PAD, PH_SKIP: begin
                n_pos = pos_inc;
                if (s_end && !complete) begin
                    n_phase = PH_CHUNK;
                    n_pos   = 32'd0;
                    if (r_phase != PH_SKIP) begin
                        emit   = 1'b1;
                        e_kind = KIND_ERROR;
                        e_code = ERR_END;
                    end
                end else begin
                    if (r_phase == PH_PHDR) begin
                        priority if (p == POS_PAD_HI || p == POS_PAD_LO) begin
                            n_pad = pad_new;
                        end else if (p == POS_CHANNEL) begin
                            n_channel = b;
                        end else if (p == POS_TYPE) begin
                            n_type = b;
                        end else if (p >= POS_TIME && p < POS_RATE) begin
                            n_time = {r_time[23:0], b};
                        end else if (p >= POS_RATE && p < POS_RATE_END) begin
                            n_rate = {r_rate[23:0], b};
                        end else begin
                            n_pad = r_pad;
                        end
                        if (p == POS_PAD_LO) begin
                            n_dend = r_size - {16'd0, pad_new};
                            if ({16'd0, pad_new} > r_size - PAYLOAD_HDR) begin
                                n_phase = PH_SKIP;
                                emit    = 1'b1;
                                e_kind  = KIND_ERROR;
                                e_code  = ERR_PAD;
                            end
                        end else if (p == POS_HDR_LAST) begin
                            emit    = 1'b1;
                            e_kind  = KIND_HEADER;
                            e_last  = (r_dend == PAYLOAD_HDR);
                            n_phase = (r_dend == PAYLOAD_HDR) ? PH_PAD : PH_DATA;
                        end
                    end else if (r_phase == PH_DATA) begin
                        if (!r_filter_on || r_type == r_wanted_type) begin
                            emit   = 1'b1;
                            e_kind = KIND_DATA;
                            e_byte = b;
                            e_last = data_last;
                        end
                        if (data_last) begin
                            n_phase = PH_PAD;
                        end
                    end
                    if (complete || s_end) begin
                        n_phase = PH_CHUNK;
                        n_pos   = 32'd0;
                    end
                end
            end
            default: begin
                n_phase = PH_CHUNK;
                n_pos   = 32'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_CHUNK;
            r_pos         <= 32'd0;
            r_out_valid   <= 1'b0;
            r_filter_on   <= 1'b0;
            r_wanted_type <= 8'd0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
            end
            if (accept && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_FILTER_ON) begin
                    r_filter_on <= i_cfg_data[0];
                end else if (i_cfg_index == CFG_WANTED_TYPE) begin
                    r_wanted_type <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_magic   <= n_magic;
            r_size    <= n_size;
            r_pad     <= n_pad;
            r_channel <= n_channel;
            r_type    <= n_type;
            r_time    <= n_time;
            r_rate    <= n_rate;
            r_dend    <= n_dend;
        end
        if (accept && emit) begin
            r_out.kind           <= e_kind;
            r_out.error_code     <= e_code;
            r_out.chunk_magic    <= n_magic;
            r_out.payload_length <= n_size;
            r_out.pad_length     <= n_pad;
            r_out.channel_number <= n_channel;
            r_out.payload_type   <= n_type;
            r_out.frm_time       <= n_time;
            r_out.frm_rate       <= n_rate;
            r_out.out_byte       <= e_byte;
            r_out.last_of_chunk  <= e_last;
        end
    end

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid)
        else $error("input stalled with empty output register");

    a_end_resyncs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && s_end |=> r_phase == PH_CHUNK && r_pos == 32'd0)
        else $error("stream end did not return to chunk header");

    a_chunk_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_CHUNK |-> r_pos < 32'd8)
        else $error("chunk header position out of range");

    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == KIND_ERROR |->
            !r_out.last_of_chunk && r_out.out_byte == 8'd0)
        else $error("error record carries data fields");

    a_data_before_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_pos < r_dend && r_dend <= r_size)
        else $error("data phase past data end");

endmodule
